[design/mevs_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the missing energy vector sum block: field widths, interface types,
// the back-end state type and the sine/cosine and angle-boundary tables built at elaboration.
// No dependencies.
package mevs_pkg;

	localparam int ANGLE_BITS     = 10;
	localparam int ENERGY_BITS    = 16;
	localparam int ACC_BITS       = 32;
	localparam int TRIG_FRAC_BITS = 15;
	localparam int RAPIDITY_BITS  = 12;
	localparam int MAG_BITS       = 32;
	localparam int BOUND_FRAC     = 30;

	localparam int QUARTER_BITS   = ANGLE_BITS - 2;
	localparam int TRIG_ENTRIES   = 1 << QUARTER_BITS;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
	localparam int PROD_W         = ENERGY_BITS + TRIG_W;
	localparam int TERM_W         = PROD_W + 1 - TRIG_FRAC_BITS;
	localparam int BOUND_IDX_BITS = ANGLE_BITS - 3;
	localparam int BOUND_ENTRIES  = 1 << BOUND_IDX_BITS;
	localparam int BOUND_W        = BOUND_FRAC + 1;
	localparam int SQ_W           = 2 * ACC_BITS;
	localparam int CMP_W          = ACC_BITS + BOUND_W;

	localparam int IN_FIELDS_W    = ENERGY_BITS + ANGLE_BITS + RAPIDITY_BITS;
	localparam int IN_DATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W   = 2 * ACC_BITS + MAG_BITS + ANGLE_BITS;
	localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W      = OUT_DATA_W - OUT_FIELDS_W;

	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_BITS      = 1;

	localparam logic SIDE_FWD = 1'b0;
	localparam logic SIDE_BWD = 1'b1;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam int TAYLOR_TERMS = 16;
	// (2k+2)(2k+3) and (2k+1)(2k+2) for the sine and cosine series terms
	localparam int TAYLOR_SIN_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272,
		342, 420, 506, 600, 702, 812, 930, 1056};
	localparam int TAYLOR_COS_DIV [TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240,
		306, 380, 462, 552, 650, 756, 870, 992};

	typedef logic signed [ACC_BITS-1:0] acc_t;

	typedef struct packed {
		acc_t x_fwd;
		acc_t y_fwd;
		acc_t x_bwd;
		acc_t y_bwd;
	} sums_t;

	typedef struct packed {
		logic  valid;
		sums_t sums;
	} q_push_t;

	typedef struct packed {
		logic  valid;
		sums_t sums;
	} q_head_t;

	typedef struct packed {
		logic                         side;
		acc_t                         sum_x;
		acc_t                         sum_y;
		logic [MAG_BITS-1:0]          magnitude;
		logic signed [ANGLE_BITS-1:0] direction;
	} result_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_LOAD,
		BK_SQ_X,
		BK_SQ_Y,
		BK_SUM,
		BK_ROOT,
		BK_S_RD,
		BK_S_MUL,
		BK_S_CMP,
		BK_EMIT
	} back_state_t;

	typedef logic [TRIG_ENTRIES-1:0][2*TRIG_W-1:0]   trig_tab_t;
	typedef logic [BOUND_ENTRIES-1:0][2*BOUND_W-1:0] bound_tab_t;

	// Low 64 bits of (a * b) >> s.
	function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int unsigned s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	// Sine and cosine of r*pi/2^(bits-1) from a Q60 Taylor series, rounded to frac bits.
	// Returns {sine, cosine}, 64 bits each.
	function automatic logic [127:0] qtrig(logic [63:0] r, int unsigned bits,
		int unsigned frac);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        ts;
		logic [63:0]        tc;
		logic signed [63:0] ss;
		logic signed [63:0] sc;
		logic [63:0]        sn;
		logic [63:0]        cs;
		int unsigned        rs;
		x  = mulsh(r, PI_Q60, bits - 1);
		x2 = mulsh(x, x, 60);
		ts = x;
		tc = 64'd1 << 60;
		ss = '0;
		sc = '0;
		rs = 60 - frac;
		for (int k = 0; k < TAYLOR_TERMS; k++) begin
			if ((k & 1) != 0) begin
				ss = ss - $signed(ts);
				sc = sc - $signed(tc);
			end else begin
				ss = ss + $signed(ts);
				sc = sc + $signed(tc);
			end
			ts = mulsh(ts, x2, 60) / 64'(TAYLOR_SIN_DIV[k]);
			tc = mulsh(tc, x2, 60) / 64'(TAYLOR_COS_DIV[k]);
		end
		if (ss < 0) ss = '0;
		if (sc < 0) sc = '0;
		sn = (64'(ss) + (64'd1 << (rs - 1))) >> rs;
		cs = (64'(sc) + (64'd1 << (rs - 1))) >> rs;
		return {sn, cs};
	endfunction

	// Quarter-wave table, entry r holds {sin, cos} of r*pi/512.
	function automatic trig_tab_t build_trig_tab();
		trig_tab_t    tab;
		logic [127:0] t;
		for (int r = 0; r < TRIG_ENTRIES; r++) begin
			t = qtrig(64'(r), ANGLE_BITS, TRIG_FRAC_BITS);
			tab[r] = {t[64 +: TRIG_W], t[0 +: TRIG_W]};
		end
		return tab;
	endfunction

	// Half-step boundaries of the first octant, entry j holds {sin, cos} of (2j+1)*pi/1024.
	function automatic bound_tab_t build_bound_tab();
		bound_tab_t   tab;
		logic [127:0] t;
		for (int j = 0; j < BOUND_ENTRIES; j++) begin
			t = qtrig(64'(2 * j + 1), ANGLE_BITS + 1, BOUND_FRAC);
			tab[j] = {t[64 +: BOUND_W], t[0 +: BOUND_W]};
		end
		return tab;
	endfunction

	localparam trig_tab_t  TRIG_TAB  = build_trig_tab();
	localparam bound_tab_t BOUND_TAB = build_bound_tab();

endpackage

[design/mevs_front.sv]
`timescale 1ns / 1ps
// Front end: takes cells, looks up sine and cosine, forms the rounded energy terms and keeps
// the forward and backward accumulators. Pushes the event's sums at its last cell. Uses mevs_pkg.
module mevs_front import mevs_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ENERGY_BITS-1:0]          in_energy,
	input  logic signed [ANGLE_BITS-1:0]    in_angle,
	input  logic signed [RAPIDITY_BITS-1:0] in_rapidity,
	input  logic                            in_end,
	input  logic                            q_full,
	output q_push_t                         push
);

	function automatic acc_t sat_add(acc_t acc, logic signed [TERM_W-1:0] term);
		logic signed [ACC_BITS:0] v;
		v = {acc[ACC_BITS-1], acc} + (ACC_BITS + 1)'(term);
		if (v[ACC_BITS] != v[ACC_BITS-1]) begin
			return v[ACC_BITS] ? {1'b1, {(ACC_BITS - 1){1'b0}}} : {1'b0, {(ACC_BITS - 1){1'b1}}};
		end
		return v[ACC_BITS-1:0];
	endfunction

	logic                     advance;
	logic [1:0]               quad;
	logic [2*TRIG_W-1:0]      trig_entry;
	logic [TRIG_W-1:0]        c0;
	logic [TRIG_W-1:0]        s0;

	logic                     valid_s1;
	logic [ENERGY_BITS-1:0]   energy_s1;
	logic [TRIG_W-1:0]        cmag_s1;
	logic [TRIG_W-1:0]        smag_s1;
	logic                     cneg_s1;
	logic                     sneg_s1;
	logic                     fwd_s1;
	logic                     end_s1;

	logic                     valid_s2;
	logic [PROD_W-1:0]        prodx_s2;
	logic [PROD_W-1:0]        prody_s2;
	logic                     cneg_s2;
	logic                     sneg_s2;
	logic                     fwd_s2;
	logic                     end_s2;

	logic                     valid_s3;
	logic signed [TERM_W-1:0] tx_s3;
	logic signed [TERM_W-1:0] ty_s3;
	logic                     fwd_s3;
	logic                     end_s3;

	logic [PROD_W:0]          rndx;
	logic [PROD_W:0]          rndy;
	logic [TERM_W-1:0]        magx;
	logic [TERM_W-1:0]        magy;

	acc_t fx_q, fy_q, bx_q, by_q;
	acc_t fx_nx, fy_nx, bx_nx, by_nx;

	// The whole pipeline holds while an event end waits for room in the queue.
	assign advance  = !(valid_s3 && end_s3 && q_full);
	assign in_ready = advance;

	assign quad       = in_angle[ANGLE_BITS-1 -: 2];
	assign trig_entry = TRIG_TAB[in_angle[QUARTER_BITS-1:0]];
	assign c0         = trig_entry[TRIG_W-1:0];
	assign s0         = trig_entry[2*TRIG_W-1:TRIG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// Quadrant symmetry: odd quadrants swap sine and cosine.
			energy_s1 <= in_energy;
			cmag_s1   <= quad[0] ? s0 : c0;
			smag_s1   <= quad[0] ? c0 : s0;
			cneg_s1   <= quad[1] ^ quad[0];
			sneg_s1   <= quad[1];
			fwd_s1    <= !in_rapidity[RAPIDITY_BITS-1] && (in_rapidity != '0);
			end_s1    <= in_end;

			prodx_s2  <= PROD_W'(energy_s1) * PROD_W'(cmag_s1);
			prody_s2  <= PROD_W'(energy_s1) * PROD_W'(smag_s1);
			cneg_s2   <= cneg_s1;
			sneg_s2   <= sneg_s1;
			fwd_s2    <= fwd_s1;
			end_s2    <= end_s1;

			tx_s3     <= cneg_s2 ? -$signed(magx) : $signed(magx);
			ty_s3     <= sneg_s2 ? -$signed(magy) : $signed(magy);
			fwd_s3    <= fwd_s2;
			end_s3    <= end_s2;
		end
	end

	// Rounding half away from zero is done on the magnitude before the sign is applied.
	always_comb begin
		rndx = {1'b0, prodx_s2} + (PROD_W + 1)'(1 << (TRIG_FRAC_BITS - 1));
		rndy = {1'b0, prody_s2} + (PROD_W + 1)'(1 << (TRIG_FRAC_BITS - 1));
		magx = rndx[PROD_W:TRIG_FRAC_BITS];
		magy = rndy[PROD_W:TRIG_FRAC_BITS];
	end

	always_comb begin
		fx_nx = fwd_s3 ? sat_add(fx_q, tx_s3) : fx_q;
		fy_nx = fwd_s3 ? sat_add(fy_q, ty_s3) : fy_q;
		bx_nx = fwd_s3 ? bx_q : sat_add(bx_q, tx_s3);
		by_nx = fwd_s3 ? by_q : sat_add(by_q, ty_s3);

		push.valid      = valid_s3 && end_s3 && advance;
		push.sums.x_fwd = fx_nx;
		push.sums.y_fwd = fy_nx;
		push.sums.x_bwd = bx_nx;
		push.sums.y_bwd = by_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= '0;
			fy_q <= '0;
			bx_q <= '0;
			by_q <= '0;
		end else if (advance && valid_s3) begin
			if (end_s3) begin
				fx_q <= '0;
				fy_q <= '0;
				bx_q <= '0;
				by_q <= '0;
			end else begin
				fx_q <= fx_nx;
				fy_q <= fy_nx;
				bx_q <= bx_nx;
				by_q <= by_nx;
			end
		end
	end

endmodule

[design/mevs_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of finished event sums between the front and back ends.
// Uses mevs_pkg.
module mevs_queue import mevs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t push,
	input  logic    pop,
	output logic    full,
	output q_head_t head
);

	sums_t                entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = (count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.sums  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.sums;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + (QPTR_BITS + 1)'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - (QPTR_BITS + 1)'(1);
			end
		end
	end

endmodule

[design/mevs_back.sv]
`timescale 1ns / 1ps
// Back end: for each queued event produces the forward and then the backward result, with a
// bit-serial square root for the magnitude and a table-driven binary search for the angle.
// Uses mevs_pkg.
module mevs_back import mevs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output result_t res,
	output logic    res_valid,
	input  logic    res_ready
);

	back_state_t state_q, state_nx;
	logic        side_q;
	logic        emit_go;
	logic        out_valid_q;
	result_t     out_q;

	acc_t                x_sel, y_sel;
	acc_t                x_q, y_q;
	logic [ACC_BITS-1:0] ax_q, ay_q;
	logic [ACC_BITS-1:0] bx_q, by_q;
	logic                swap_q;
	logic                zero_q;

	logic [SQ_W-1:0] sqx_q, sqy_q;
	logic [SQ_W-1:0] rem_q, res_q, bit_q;
	logic [SQ_W-1:0] root_sub;
	logic            root_take;

	logic [BOUND_IDX_BITS:0]   lo_q, hi_q;
	logic [BOUND_IDX_BITS-1:0] mid_q;
	logic [BOUND_IDX_BITS+1:0] lo_sum;
	logic [BOUND_IDX_BITS-1:0] mid_nx;
	logic [2*BOUND_W-1:0]      bound_entry;
	logic [BOUND_W-1:0]        cb_q, sb_q;
	logic [CMP_W-1:0]          pc_q, ps_q;
	logic                      ge;
	logic [BOUND_IDX_BITS:0]   lo_nx, hi_nx;
	logic                      search_more;

	logic signed [ANGLE_BITS:0]   n_a, n_b, n_c, n_d;
	logic signed [ANGLE_BITS-1:0] dir_nx;

	assign x_sel = (side_q == SIDE_BWD) ? head.sums.x_bwd : head.sums.x_fwd;
	assign y_sel = (side_q == SIDE_BWD) ? head.sums.y_bwd : head.sums.y_fwd;

	assign root_sub  = res_q + bit_q;
	assign root_take = (rem_q >= root_sub);

	assign lo_sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_nx      = lo_sum[BOUND_IDX_BITS:1];
	assign bound_entry = BOUND_TAB[mid_nx];
	assign ge          = (pc_q >= ps_q);
	assign lo_nx       = ge ? ({1'b0, mid_q} + (BOUND_IDX_BITS + 1)'(1)) : lo_q;
	assign hi_nx       = ge ? hi_q : {1'b0, mid_q};
	assign search_more = (lo_nx < hi_nx);

	// Undo the octant fold: swap, then negative x, then negative y. The +pi code wraps.
	always_comb begin
		n_a = $signed({{(ANGLE_BITS - BOUND_IDX_BITS){1'b0}}, lo_q});
		n_b = swap_q ? ((ANGLE_BITS + 1)'(1 << (ANGLE_BITS - 2)) - n_a) : n_a;
		n_c = x_q[ACC_BITS-1] ? ((ANGLE_BITS + 1)'(1 << (ANGLE_BITS - 1)) - n_b) : n_b;
		n_d = y_q[ACC_BITS-1] ? -n_c : n_c;
		dir_nx = zero_q ? '0 : n_d[ANGLE_BITS-1:0];
	end

	assign emit_go   = (state_q == BK_EMIT) && (!out_valid_q || res_ready);
	assign pop       = emit_go && (side_q == SIDE_BWD);
	assign res       = out_q;
	assign res_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) state_nx = BK_LOAD;
			end
			BK_LOAD:  state_nx = BK_SQ_X;
			BK_SQ_X:  state_nx = BK_SQ_Y;
			BK_SQ_Y:  state_nx = BK_SUM;
			BK_SUM:   state_nx = BK_ROOT;
			BK_ROOT: begin
				if (bit_q[0]) state_nx = BK_S_RD;
			end
			BK_S_RD:  state_nx = BK_S_MUL;
			BK_S_MUL: state_nx = BK_S_CMP;
			BK_S_CMP: begin
				state_nx = search_more ? BK_S_RD : BK_EMIT;
			end
			BK_EMIT: begin
				if (emit_go) state_nx = (side_q == SIDE_FWD) ? BK_LOAD : BK_IDLE;
			end
			default:  state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_LOAD: begin
				x_q  <= x_sel;
				y_q  <= y_sel;
				ax_q <= x_sel[ACC_BITS-1] ? ACC_BITS'(-x_sel) : ACC_BITS'(x_sel);
				ay_q <= y_sel[ACC_BITS-1] ? ACC_BITS'(-y_sel) : ACC_BITS'(y_sel);
			end
			BK_SQ_X: begin
				sqx_q  <= SQ_W'(ax_q) * SQ_W'(ax_q);
				swap_q <= (ay_q > ax_q);
				bx_q   <= (ay_q > ax_q) ? ay_q : ax_q;
				by_q   <= (ay_q > ax_q) ? ax_q : ay_q;
				zero_q <= (ax_q == '0) && (ay_q == '0);
			end
			BK_SQ_Y: begin
				sqy_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
			end
			BK_SUM: begin
				rem_q <= sqx_q + sqy_q;
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
				lo_q  <= '0;
				hi_q  <= (BOUND_IDX_BITS + 1)'(BOUND_ENTRIES);
			end
			BK_ROOT: begin
				if (root_take) begin
					rem_q <= rem_q - root_sub;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			BK_S_RD: begin
				mid_q <= mid_nx;
				cb_q  <= bound_entry[BOUND_W-1:0];
				sb_q  <= bound_entry[2*BOUND_W-1:BOUND_W];
			end
			BK_S_MUL: begin
				pc_q <= CMP_W'(by_q) * CMP_W'(cb_q);
				ps_q <= CMP_W'(bx_q) * CMP_W'(sb_q);
			end
			BK_S_CMP: begin
				lo_q <= lo_nx;
				hi_q <= hi_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			side_q      <= SIDE_FWD;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
				side_q      <= (side_q == SIDE_FWD) ? SIDE_BWD : SIDE_FWD;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q.side      <= side_q;
			out_q.sum_x     <= x_q;
			out_q.sum_y     <= y_q;
			out_q.magnitude <= res_q[MAG_BITS-1:0];
			out_q.direction <= dir_nx;
		end
	end

endmodule

[design/missing_energy_vector_sum.sv]
`timescale 1ns / 1ps
// Top level of the missing energy vector sum block: stream ports, front end, sums queue and
// back end, plus a few checks on the internal hand-over. Uses mevs_pkg and the mevs_* modules.
//
// The block takes one detector cell per transfer (transverse energy, azimuth code and
// pseudorapidity) and adds energy*cos and energy*sin of the cell to the forward sums when the
// pseudorapidity is above zero, otherwise to the backward sums. Sine and cosine come from a
// quarter-wave table with 15 fraction bits; each term is rounded half away from zero and every
// addition saturates at the 32-bit signed limits. The transfer with tlast set closes the event:
// after that cell is added, two results follow, the forward one (tuser 0) and then the backward
// one (tuser 1, tlast 1), each with both sums, the rounded-down vector magnitude and the
// direction as atan2 in steps of pi/512 (zero when both sums are zero, +pi shown as -pi).
// The sums are cleared for the next event at once. Cells are taken at one per clock through a
// three-stage front pipeline that stalls only when an event ends while the two-entry queue of
// finished events is full. For each result the back end loads and squares the sums, finds the
// square root one result bit per clock, runs 7 or 8 search steps (read, multiply, compare)
// against the angle-boundary table and then emits; events that arrive faster than the back
// end finishes them back up into the queue and then the input. A finished result waits in the
// output register and holds the back end only when the next result is ready to emit.
// There is no start-up clearing pass.
module missing_energy_vector_sum import mevs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// cell_energy [15:0], cell_angle [25:16], cell_rapidity [37:26], zero fill [39:38]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// event_end: marks the last cell of the event
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// sum_x [31:0], sum_y [63:32], magnitude [95:64], direction [105:96], zero fill [111:106]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// side: 0 forward, 1 backward
	output logic                  m_axis_tuser,
	// last: set on the backward result, which ends the event
	output logic                  m_axis_tlast
);

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;
	result_t res;

	mevs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_energy   (s_axis_tdata[ENERGY_BITS-1:0]),
		.in_angle    (s_axis_tdata[ENERGY_BITS +: ANGLE_BITS]),
		.in_rapidity (s_axis_tdata[ENERGY_BITS + ANGLE_BITS +: RAPIDITY_BITS]),
		.in_end      (s_axis_tlast),
		.q_full      (q_full),
		.push        (push)
	);

	mevs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	mevs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.direction, res.magnitude, res.sum_y, res.sum_x};
	assign m_axis_tuser = res.side;
	assign m_axis_tlast = (res.side == SIDE_BWD);

	// Cells are only held back by a full queue of finished events.
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_full)
		else $error("input stalled while the sums queue had room");

	// The back end releases an event only while one is queued.
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("sums queue popped while empty");

	// Once the forward result is transferred, the next result shown is the backward one.
	a_side_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tuser == SIDE_FWD)
		|=> !m_axis_tvalid || (m_axis_tuser == SIDE_BWD))
		else $error("forward result not followed by backward result");

	// A zero vector has zero magnitude and zero direction.
	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.sum_x == '0) && (res.sum_y == '0)
		|-> (res.magnitude == '0) && (res.direction == '0))
		else $error("zero sums with nonzero magnitude or direction");

endmodule

[sim/tb_missing_energy_vector_sum.sv]
`timescale 1ns / 1ps
// Testbench for missing_energy_vector_sum: streams detector cells into the block and checks every
// forward and backward result against a bit-exact predictor of the sums, magnitude and direction.
// Depends on mevs_pkg for the stream widths and side codes, and on the RTL of the block.
module tb_missing_energy_vector_sum;

	import mevs_pkg::IN_DATA_W;
	import mevs_pkg::OUT_DATA_W;
	import mevs_pkg::SIDE_FWD;
	import mevs_pkg::SIDE_BWD;

	// Fixed-point constants of the predictor, matching the block's configuration.
	localparam logic [63:0] HALF_TURN_Q60 = 64'h3243F6A8885A308D;
	localparam int          CELL_FRAC     = 15;
	localparam int          EDGE_FRAC     = 30;
	localparam int          QUARTER_STEPS = 256;
	localparam int          OCTANT_STEPS  = 128;
	localparam longint      SUM_MAX       = 64'sd2147483647;
	localparam longint      SUM_MIN       = -64'sd2147483648;
	localparam int          PRINT_LIMIT   = 100;

	// One result as it should appear on the master side.
	typedef struct packed {
		logic                side;
		logic signed [31:0]  sum_x;
		logic signed [31:0]  sum_y;
		logic [31:0]         magnitude;
		logic signed [9:0]   direction;
		logic                last;
	} side_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	// Quarter-wave sine and cosine in Q15, and the octant boundary sine and cosine in Q30.
	logic [63:0]  quarter_sin [QUARTER_STEPS];
	logic [63:0]  quarter_cos [QUARTER_STEPS];
	logic [63:0]  boundary_sin [OCTANT_STEPS];
	logic [63:0]  boundary_cos [OCTANT_STEPS];

	// Predicted running sums of the event in progress, one pair per side.
	longint       fwd_x = 0;
	longint       fwd_y = 0;
	longint       bwd_x = 0;
	longint       bwd_y = 0;

	side_result_t expected_side_sums [$];
	int           mismatch_count = 0;
	bit           gaps_on = 1'b1;

	missing_energy_vector_sum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------------------------

	// The low 64 bits of the full 128-bit product shifted right by s.
	function automatic logic [63:0] prod_shr(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		return wide[s +: 64];
	endfunction

	// Sine and cosine of r*pi/2^pi_shift by a sixteen-term Taylor series held in Q60, each
	// term truncated, then rounded half up to frac fraction bits. A negative sum is taken as
	// zero before rounding.
	function automatic void series_sincos(input logic [63:0] r, input int pi_shift,
		input int frac, output logic [63:0] sn, output logic [63:0] cs);
		logic [63:0]        ang;
		logic [63:0]        ang2;
		logic [63:0]        s_term;
		logic [63:0]        c_term;
		logic signed [63:0] s_acc;
		logic signed [63:0] c_acc;
		int                 drop;
		int                 k;
		ang    = prod_shr(r, HALF_TURN_Q60, pi_shift);
		ang2   = prod_shr(ang, ang, 60);
		s_term = ang;
		c_term = 64'd1 << 60;
		s_acc  = '0;
		c_acc  = '0;
		drop   = 60 - frac;
		for (k = 0; k < 16; k++) begin
			if (k % 2 == 1) begin
				s_acc -= $signed(s_term);
				c_acc -= $signed(c_term);
			end else begin
				s_acc += $signed(s_term);
				c_acc += $signed(c_term);
			end
			s_term = prod_shr(s_term, ang2, 60) / 64'((2 * k + 2) * (2 * k + 3));
			c_term = prod_shr(c_term, ang2, 60) / 64'((2 * k + 1) * (2 * k + 2));
		end
		if (s_acc < 0) s_acc = '0;
		if (c_acc < 0) c_acc = '0;
		sn = ($unsigned(s_acc) + (64'd1 << (drop - 1))) >> drop;
		cs = ($unsigned(c_acc) + (64'd1 << (drop - 1))) >> drop;
	endfunction

	task automatic build_trig_tables();
		int i;
		for (i = 0; i < QUARTER_STEPS; i++)
			series_sincos(64'(i), 9, CELL_FRAC, quarter_sin[i], quarter_cos[i]);
		// Boundaries sit half a step above each code: (2j+1)*pi/1024.
		for (i = 0; i < OCTANT_STEPS; i++)
			series_sincos(64'(2 * i + 1), 10, EDGE_FRAC, boundary_sin[i], boundary_cos[i]);
	endtask

	// Signed sine and cosine of a 10-bit azimuth code, mapped from the first quadrant.
	function automatic void cell_sincos(input logic [9:0] code, output longint sn,
		output longint cs);
		longint s0;
		longint c0;
		s0 = longint'(quarter_sin[code[7:0]]);
		c0 = longint'(quarter_cos[code[7:0]]);
		case (code[9:8])
			2'd0: begin
				sn = s0;
				cs = c0;
			end
			2'd1: begin
				sn = c0;
				cs = -s0;
			end
			2'd2: begin
				sn = -s0;
				cs = -c0;
			end
			default: begin
				sn = -c0;
				cs = s0;
			end
		endcase
	endfunction

	// Energy times a Q15 trig value, rounded to energy units half away from zero.
	function automatic longint scaled_term(input longint energy, input longint trig);
		longint prod;
		longint mag;
		prod = energy * trig;
		mag  = (prod < 0) ? -prod : prod;
		mag  = (mag + (64'sd1 << (CELL_FRAC - 1))) >> CELL_FRAC;
		return (prod < 0) ? -mag : mag;
	endfunction

	function automatic longint clamp_sum(input longint v);
		if (v > SUM_MAX) return SUM_MAX;
		if (v < SUM_MIN) return SUM_MIN;
		return v;
	endfunction

	// Floor of the square root of x^2 + y^2, found one result bit at a time from the top.
	function automatic logic [31:0] vector_length(input longint x, input longint y);
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] sq;
		logic [63:0] trial;
		logic [31:0] root;
		int          i;
		ax   = (x < 0) ? -x : x;
		ay   = (y < 0) ? -y : y;
		sq   = ax * ax + ay * ay;
		root = '0;
		for (i = 31; i >= 0; i--) begin
			trial = {32'd0, root | (32'd1 << i)};
			if (trial * trial <= sq) root = root | (32'd1 << i);
		end
		return root;
	endfunction

	// atan2(y, x) in steps of pi/512. The vector is folded into the first octant, the number
	// of half-step boundaries at or below it is counted, and the fold is then undone. A result
	// of +pi lands on the most negative code.
	function automatic logic signed [9:0] bearing(input longint x, input longint y);
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] bx;
		logic [63:0] by;
		bit          swapped;
		int          n;
		if (x == 0 && y == 0) return '0;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		while (ax > (64'd1 << 31) || ay > (64'd1 << 31)) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		swapped = ay > ax;
		bx = swapped ? ay : ax;
		by = swapped ? ax : ay;
		n = 0;
		while (n < OCTANT_STEPS && by * boundary_cos[n] >= bx * boundary_sin[n])
			n++;
		if (swapped) n = 256 - n;
		if (x < 0) n = 512 - n;
		if (y < 0) n = -n;
		return 10'(n);
	endfunction

	function automatic side_result_t side_summary(input logic side, input longint x,
		input longint y);
		side_result_t r;
		r.side      = side;
		r.sum_x     = 32'(x);
		r.sum_y     = 32'(y);
		r.magnitude = vector_length(x, y);
		r.direction = bearing(x, y);
		r.last      = (side == SIDE_BWD);
		return r;
	endfunction

	// Adds one accepted cell to its side and, at the end of an event, queues the forward
	// result followed by the backward one and clears all four sums.
	task automatic accumulate_cell(input logic [15:0] energy, input logic [9:0] angle,
		input logic signed [11:0] rapidity, input logic event_end);
		longint sn;
		longint cs;
		longint tx;
		longint ty;
		cell_sincos(angle, sn, cs);
		tx = scaled_term(longint'(energy), cs);
		ty = scaled_term(longint'(energy), sn);
		// Only a strictly positive pseudorapidity counts as forward; zero goes backward.
		if (rapidity > 0) begin
			fwd_x = clamp_sum(fwd_x + tx);
			fwd_y = clamp_sum(fwd_y + ty);
		end else begin
			bwd_x = clamp_sum(bwd_x + tx);
			bwd_y = clamp_sum(bwd_y + ty);
		end
		if (event_end) begin
			expected_side_sums.insert(expected_side_sums.size(),
				side_summary(SIDE_FWD, fwd_x, fwd_y));
			expected_side_sums.insert(expected_side_sums.size(),
				side_summary(SIDE_BWD, bwd_x, bwd_y));
			fwd_x = 0;
			fwd_y = 0;
			bwd_x = 0;
			bwd_y = 0;
		end
	endtask

	// ------------------------------------------------------------------------------------------
	// Driving the slave side
	// ------------------------------------------------------------------------------------------

	// Presents one cell from a falling edge, with an occasional idle gap in front of it, and
	// holds it until a rising edge sees tvalid and tready together. tvalid is left high so
	// that the next cell follows straight on unless a gap is drawn.
	task automatic push_cell(input logic [15:0] energy, input logic [9:0] angle,
		input logic [11:0] rapidity, input logic event_end);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tdata          = '0;
		s_axis_tdata[15:0]    = energy;
		s_axis_tdata[25:16]   = angle;
		s_axis_tdata[37:26]   = rapidity;
		s_axis_tlast          = event_end;
		s_axis_tvalid         = 1'b1;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		accumulate_cell(energy, angle, rapidity, event_end);
	endtask

	// A cell with random content: any angle, mostly full-range energies and pseudorapidities within
	// +-1280, with a share of tiny and extreme energies and of pseudorapidities right at the split.
	task automatic random_cell(input logic event_end);
		logic [15:0] energy;
		logic [9:0]  angle;
		logic [11:0] rapidity;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) energy = 16'($urandom);
		else if (pick < 90) energy = 16'($urandom_range(0, 3));
		else energy = pick[0] ? 16'hFFFF : 16'h0000;
		angle = 10'($urandom_range(0, 1023));
		pick = $urandom_range(0, 99);
		if (pick < 70) rapidity = 12'(int'($urandom_range(0, 2560)) - 1280);
		else if (pick < 90) rapidity = 12'(int'($urandom_range(0, 2)) - 1);
		else rapidity = 12'($urandom);
		push_cell(energy, angle, rapidity, event_end);
	endtask

	// ------------------------------------------------------------------------------------------
	// Master side: random back-pressure and the result checker
	// ------------------------------------------------------------------------------------------

	always @(negedge clk)
		m_axis_tready <= !gaps_on || $urandom_range(0, 99) >= 9;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Every completed transfer on the master side is compared with the oldest expectation.
	always @(posedge clk) begin
		side_result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (expected_side_sums.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
			end else begin
				want = expected_side_sums.pop_front();
				if (m_axis_tuser !== want.side)
					report_mismatch("side", m_axis_tuser, want.side);
				if (m_axis_tdata[31:0] !== want.sum_x)
					report_mismatch("sum_x", m_axis_tdata[31:0], want.sum_x);
				if (m_axis_tdata[63:32] !== want.sum_y)
					report_mismatch("sum_y", m_axis_tdata[63:32], want.sum_y);
				if (m_axis_tdata[95:64] !== want.magnitude)
					report_mismatch("magnitude", m_axis_tdata[95:64], want.magnitude);
				if (m_axis_tdata[105:96] !== want.direction)
					report_mismatch("direction", m_axis_tdata[105:96], want.direction);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	// ------------------------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------------------------

	// Hand-picked cells: zero and full energy, the axis angles and both ends of the azimuth
	// range, pseudorapidity at zero, just either side of it and at the field limits, small
	// energies where the rounding of each term matters, a side left empty, and two opposite
	// cells that cancel to a zero vector.
	task automatic test_directed_cells();
		push_cell(16'd0, 10'd0, 12'd1, 1'b1);
		push_cell(16'hFFFF, 10'd0, 12'd1, 1'b0);
		// Straight towards -pi on the backward side: the direction wraps to the lowest code.
		push_cell(16'hFFFF, -10'sd512, -12'sd1, 1'b1);
		push_cell(16'hFFFF, 10'd256, 12'd0, 1'b0);
		push_cell(16'hFFFF, -10'sd256, 12'd2047, 1'b0);
		push_cell(16'hFFFF, 10'd511, -12'sd2048, 1'b0);
		push_cell(16'hFFFF, 10'd128, 12'd1280, 1'b0);
		push_cell(16'hFFFF, -10'sd384, -12'sd1280, 1'b1);
		push_cell(16'd1, 10'd171, 12'd5, 1'b0);
		push_cell(16'd1, -10'sd341, -12'sd5, 1'b0);
		push_cell(16'd3, 10'd85, 12'd1, 1'b1);
		push_cell(16'd2, 10'd200, 12'd1, 1'b0);
		push_cell(16'd1, -10'sd60, -12'sd3, 1'b1);
		// Two forward cells half a turn apart cancel exactly; the backward side stays empty.
		push_cell(16'd50000, 10'd100, 12'd9, 1'b0);
		push_cell(16'd50000, -10'sd412, 12'd9, 1'b1);
		push_cell(16'd65534, 10'd384, -12'sd700, 1'b0);
		push_cell(16'd32768, -10'sd128, 12'd700, 1'b1);
	endtask

	// A long event of full-energy cells along the axes that builds up large forward sums and
	// a large negative backward x sum, so that the wide end of the magnitude and direction
	// arithmetic is exercised.
	task automatic test_large_sums();
		int i;
		for (i = 0; i < 60; i++) begin
			push_cell(16'hFFFF, 10'd0, 12'd1, 1'b0);
			push_cell(16'hFFFF, 10'd256, 12'd1, 1'b0);
			push_cell(16'hFFFF, -10'sd512, -12'sd1, 1'b0);
		end
		push_cell(16'hFFFF, -10'sd256, 12'd1, 1'b0);
		push_cell(16'hFFFF, 10'd0, -12'sd1, 1'b1);
	endtask

	// Single-cell events back to back, faster than the back end can finish them, so the
	// queue of finished events fills and the slave side has to stall.
	task automatic test_event_backlog();
		int i;
		for (i = 0; i < 24; i++)
			random_cell(1'b1);
	endtask

	// Random events of random length, mostly short, now and then a long one.
	task automatic test_random_events(input int cell_target);
		int sent;
		int len;
		int pick;
		int i;
		sent = 0;
		while (sent < cell_target) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) len = 1;
			else if (pick < 80) len = $urandom_range(2, 12);
			else if (pick < 95) len = $urandom_range(13, 40);
			else len = $urandom_range(41, 120);
			for (i = 0; i < len; i++)
				random_cell(i == len - 1);
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------------------------

	initial begin
		build_trig_tables();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cells();
		// The large-sum run has neither idle gaps nor back-pressure.
		gaps_on = 1'b0;
		test_large_sums();
		gaps_on = 1'b1;
		test_event_backlog();
		test_random_events(600);
		// A long quiet stretch with no idling on either side.
		gaps_on = 1'b0;
		test_random_events(400);
		gaps_on = 1'b1;
		test_random_events(450);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tlast  = 1'b0;
		while (expected_side_sums.size() != 0)
			@(posedge clk);
		// Let the back end run on after the last expected result; anything extra shows up here.
		repeat (200) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb_missing_energy_vector_sum: PASS");
		end else begin
			$display("tb_missing_energy_vector_sum: FAIL");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run (about 1700 cells, even if every one of them
	// ended an event and waited the full back-end time with gaps and stalls).
	initial begin
		#40_000_000;
		$display("tb_missing_energy_vector_sum: FAIL");
		$finish;
	end

endmodule
